// ===== src/sha1_pkg.sv =====
package sha1_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned BLOCK_W      = WORD_W * BLOCK_WORDS;
    localparam int unsigned CHAIN_WORDS  = 5;
    localparam int unsigned DIGEST_W     = WORD_W * CHAIN_WORDS;
    localparam int unsigned DIGEST_BYTES = 20;
    localparam int unsigned ROUNDS       = 80;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [5:0] POS_LEN  = 6'd56;
    localparam logic [5:0] POS_LAST = 6'd63;

    localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
    localparam logic [4:0] OUT_LAST   = 5'(DIGEST_BYTES - 1);

    localparam logic [WORD_W-1:0] H_INIT [CHAIN_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [WORD_W-1:0] K_0 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ed9eba1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8f1bbcdc;
    localparam logic [WORD_W-1:0] K_3 = 32'hca62c1d6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_LEN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic round;
        logic fold;
        logic restart;
    } t_core_ctl;

endpackage

// ===== src/sha1_round_core.sv =====
module sha1_round_core
    import sha1_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_core_ctl           i_ctl,
    input  logic [6:0]          i_round,
    input  logic [BLOCK_W-1:0]  i_block,
    output logic [DIGEST_W-1:0] o_sum
);

    logic [WORD_W-1:0] r_w     [BLOCK_WORDS];
    logic [WORD_W-1:0] r_v     [CHAIN_WORDS];
    logic [WORD_W-1:0] r_chain [CHAIN_WORDS];

    logic [WORD_W-1:0] w_new;
    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] k_val;
    logic [WORD_W-1:0] tmp;
    logic [WORD_W-1:0] sum     [CHAIN_WORDS];

    always_comb begin
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_new[WORD_W-2:0], w_new[WORD_W-1]};
        if (i_round < 7'd20) begin
            f_val = (r_v[1] & r_v[2]) ^ (~r_v[1] & r_v[3]);
            k_val = K_0;
        end else if (i_round < 7'd40) begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_1;
        end else if (i_round < 7'd60) begin
            f_val = (r_v[1] & r_v[2]) ^ (r_v[1] & r_v[3]) ^ (r_v[2] & r_v[3]);
            k_val = K_2;
        end else begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_3;
        end
        tmp = {r_v[0][WORD_W-6:0], r_v[0][WORD_W-1:WORD_W-5]}
            + f_val + r_v[4] + k_val + r_w[0];
    end

    always_comb begin
        for (int i = 0; i < CHAIN_WORDS; i++) begin
            sum[i] = r_chain[i] + r_v[i];
        end
        o_sum = {sum[0], sum[1], sum[2], sum[3], sum[4]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                r_w[i] <= i_block[BLOCK_W-1-WORD_W*i -: WORD_W];
            end
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (i_ctl.round) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLOCK_WORDS-1] <= w_new;
            r_v[0] <= tmp;
            r_v[1] <= r_v[0];
            r_v[2] <= {r_v[1][1:0], r_v[1][WORD_W-1:2]};
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_chain[i] <= H_INIT[i];
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_chain[i] <= i_ctl.restart ? H_INIT[i] : sum[i];
            end
        end
    end

endmodule

// ===== src/sha1_stream_hasher_unit.sv =====
// sha-1 over a byte stream: s_axis carries one message byte per item (tuser low) or a finish
// item (tuser high); data bytes are taken only while idle, and every 64th byte runs the
// block (one load, 80 rounds through the single shared round adder, one fold into the
// chaining words) with s_axis held off. a finish item pads one byte per cycle up to the
// 64-bit bit length, runs one or two more blocks, then sends 20 digest bytes on m_axis,
// most significant first, tlast on the last; the hasher then starts over for a new message.
module sha1_stream_hasher_unit
    import sha1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] digest_byte
    output logic       m_axis_tlast
);

    t_state r_state, n_state;

    logic [BLOCK_W-1:0]  r_block, n_block;
    logic [5:0]          r_pos, n_pos;
    logic [63:0]         r_count, n_count;
    logic [63:0]         r_bits, n_bits;
    logic                r_fin, n_fin;
    logic                r_len_done, n_len_done;
    logic [6:0]          r_round, n_round;
    logic [DIGEST_W-1:0] r_digest, n_digest;
    logic [4:0]          r_out_cnt, n_out_cnt;

    t_core_ctl           core_ctl;
    logic [DIGEST_W-1:0] fold_sum;
    logic                s_accept;
    logic                m_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_accept = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_digest[DIGEST_W-1 -: 8];
    assign m_axis_tlast  = (r_out_cnt == OUT_LAST);

    sha1_round_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_round (r_round),
        .i_block (r_block),
        .o_sum   (fold_sum)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (r_pos == POS_LAST) begin
                        n_state = S_LOAD;
                    end else if (s_axis_tuser == KIND_FINISH) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_len_done) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (r_pos == POS_LEN) begin
                    n_state = S_LEN;
                end else if (r_pos == POS_LAST) begin
                    n_state = S_LOAD;
                end
            end
            S_LEN: begin
                if (r_pos == POS_LAST) begin
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (m_accept && m_axis_tlast) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_block    = r_block;
        n_pos      = r_pos;
        n_count    = r_count;
        n_bits     = r_bits;
        n_fin      = r_fin;
        n_len_done = r_len_done;
        n_round    = r_round;
        n_digest   = r_digest;
        n_out_cnt  = r_out_cnt;
        core_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_pos = r_pos + 6'd1;
                    if (s_axis_tuser == KIND_FINISH) begin
                        n_block    = {r_block[BLOCK_W-9:0], PAD_BYTE};
                        n_bits     = {r_count[60:0], 3'b000};
                        n_count    = '0;
                        n_fin      = 1'b1;
                        n_len_done = 1'b0;
                    end else begin
                        n_block = {r_block[BLOCK_W-9:0], s_axis_tdata};
                        n_count = r_count + 64'd1;
                        n_fin   = 1'b0;
                    end
                end
            end
            S_LOAD: begin
                core_ctl.load = 1'b1;
                n_round       = '0;
            end
            S_ROUND: begin
                core_ctl.round = 1'b1;
                n_round        = r_round + 7'd1;
            end
            S_FOLD: begin
                core_ctl.fold = 1'b1;
                if (r_fin && r_len_done) begin
                    core_ctl.restart = 1'b1;
                    n_digest         = fold_sum;
                    n_out_cnt        = '0;
                    n_fin            = 1'b0;
                end
            end
            S_PAD: begin
                if (r_pos != POS_LEN) begin
                    n_block = {r_block[BLOCK_W-9:0], 8'h00};
                    n_pos   = r_pos + 6'd1;
                end
            end
            S_LEN: begin
                n_block = {r_block[BLOCK_W-9:0], r_bits[63:56]};
                n_bits  = {r_bits[55:0], 8'h00};
                n_pos   = r_pos + 6'd1;
                if (r_pos == POS_LAST) begin
                    n_len_done = 1'b1;
                end
            end
            S_OUT: begin
                if (m_accept) begin
                    n_digest  = {r_digest[DIGEST_W-9:0], 8'h00};
                    n_out_cnt = r_out_cnt + 5'd1;
                end
            end
            default: begin
                n_block = r_block;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_count    <= '0;
            r_fin      <= 1'b0;
            r_len_done <= 1'b0;
            r_round    <= '0;
            r_out_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_count    <= n_count;
            r_fin      <= n_fin;
            r_len_done <= n_len_done;
            r_round    <= n_round;
            r_out_cnt  <= n_out_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_block  <= n_block;
        r_bits   <= n_bits;
        r_digest <= n_digest;
    end

endmodule
